[hdl/vpll_pkg.sv]
// ----------------------------------------------------------------------------
// vpll_pkg
// Shared types and constants for the voice pool linked list unit.
// ----------------------------------------------------------------------------
package vpll_pkg;

  // Default pool depth
  localparam int POOL_SIZE_DEF = 64;

  // Fixed field widths
  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int NEXT_W  = 7;
  localparam int CNT_W   = 7;
  localparam int VC_W    = 7;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_W   = PADDR_W - 2;
  localparam logic [REG_W-1:0] REG_VOICE_COUNT = '0;
  localparam int VC_RST  = 64;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC_HEAD = 2'd0,
    CMD_ALLOC_TAIL = 2'd1,
    CMD_POP_HEAD   = 2'd2,
    CMD_FREE_AFTER = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC1,
    ST_EXEC2,
    ST_WR2,
    ST_DONE
  } state_t;

  // Configuration to sequencer
  typedef struct packed {
    logic            rebuild;
    logic [VC_W-1:0] voice_count;
  } cfg_t;

endpackage

[hdl/vpll_if.sv]
// ----------------------------------------------------------------------------
// vpll_if
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface vpll_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [vpll_pkg::CMD_W-1:0]  command;
  logic [vpll_pkg::SLOT_W-1:0] prev_slot;
  logic                       prev_is_head;
  logic [vpll_pkg::SLOT_W-1:0] victim_slot;

  modport source (output valid, command, prev_slot, prev_is_head, victim_slot,
                  input ready);
  modport sink   (input valid, command, prev_slot, prev_is_head, victim_slot,
                  output ready);
endinterface

interface vpll_res_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic [vpll_pkg::SLOT_W-1:0] slot;
  logic [vpll_pkg::NEXT_W-1:0] next_slot;
  logic [vpll_pkg::CNT_W-1:0]  active_count;

  modport source (output valid, ok, slot, next_slot, active_count, input ready);
  modport sink   (input valid, ok, slot, next_slot, active_count, output ready);
endinterface

[hdl/vpll_ram.sv]
// ----------------------------------------------------------------------------
// vpll_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module vpll_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/vpll_cfg.sv]
// ----------------------------------------------------------------------------
// vpll_cfg
// APB register block: voice_count register, clamped on write; a write
// requests a rebuild of both lists.
// ----------------------------------------------------------------------------
module vpll_cfg #(
  parameter int POOL_SIZE = vpll_pkg::POOL_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vpll_pkg::PADDR_W-1:0] paddr,
  input  logic [vpll_pkg::PDATA_W-1:0] pwdata,
  output logic [vpll_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output vpll_pkg::cfg_t               cfg
);
  import vpll_pkg::*;

  localparam int VC_INIT = (VC_RST > POOL_SIZE) ? POOL_SIZE : VC_RST;

  logic [VC_W-1:0]  voice_count;
  logic             rebuild;
  logic [VC_W-1:0]  wr_val;
  logic [REG_W-1:0] reg_idx;
  logic             wr_hit;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_hit  = psel && penable && pwrite && (reg_idx == REG_VOICE_COUNT);

  // Clamp the written value into 1..POOL_SIZE
  always_comb begin
    wr_val = pwdata[VC_W-1:0];
    if (wr_val == '0) begin
      wr_val = VC_W'(1);
    end else if (int'(wr_val) > POOL_SIZE) begin
      wr_val = VC_W'(POOL_SIZE);
    end
  end

  // Register and rebuild strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      voice_count <= VC_W'(VC_INIT);
      rebuild     <= 1'b0;
    end else begin
      rebuild <= wr_hit;
      if (wr_hit) begin
        voice_count <= wr_val;
      end
    end
  end

  assign cfg = '{rebuild: rebuild, voice_count: voice_count};

  // Read back
  assign prdata = (reg_idx == REG_VOICE_COUNT) ? PDATA_W'(voice_count) : '0;

endmodule

[hdl/vpll_ctrl.sv]
// ----------------------------------------------------------------------------
// vpll_ctrl
// Command sequencer: list pointers, link RAM read-modify-write steps,
// clearing pass and result register.
// ----------------------------------------------------------------------------
module vpll_ctrl #(
  parameter int POOL_SIZE = vpll_pkg::POOL_SIZE_DEF,
  parameter int LW        = $clog2(POOL_SIZE + 1),
  parameter int AW        = $clog2(POOL_SIZE)
) (
  input  logic           clk,
  input  logic           rst,
  input  vpll_pkg::cfg_t cfg,
  vpll_cmd_if.sink       cmd,
  vpll_res_if.source     res,
  output logic           ram_we,
  output logic [AW-1:0]  ram_waddr,
  output logic [LW-1:0]  ram_wdata,
  output logic [AW-1:0]  ram_raddr,
  input  logic [LW-1:0]  ram_rdata
);
  import vpll_pkg::*;

  localparam int XW = (LW > VC_W) ? LW : VC_W;
  localparam logic [LW-1:0] END_MARK = LW'(POOL_SIZE);
  localparam logic [LW-1:0] LAST_IDX = LW'(POOL_SIZE - 1);

  state_t state, state_next;

  logic [LW-1:0]     clr_cnt;
  logic [LW-1:0]     free_head;
  logic [LW-1:0]     active_head;
  logic [LW-1:0]     active_tail;
  logic [LW-1:0]     active_total;
  cmd_t              cmd_q;
  logic [SLOT_W-1:0] prev_q;
  logic              ph_q;
  logic [SLOT_W-1:0] victim_q;
  logic              res_ok;
  logic [LW-1:0]     res_slot;
  logic [LW-1:0]     res_next;
  logic [AW-1:0]     wr2_addr;
  logic [LW-1:0]     wr2_data;

  logic [XW-1:0] vc_x;
  logic          fh_ok, ah_ok, victim_ok, prev_ok;
  logic [LW-1:0] victim_l, prev_l;
  logic          head_hit, link_hit, tot_inc, tot_dec;
  logic [LW-1:0] clr_data;

  // Range checks and list matches
  assign vc_x      = XW'(cfg.voice_count);
  assign fh_ok     = XW'(free_head) < vc_x;
  assign ah_ok     = XW'(active_head) < vc_x;
  assign victim_ok = XW'(victim_q) < vc_x;
  assign prev_ok   = XW'(prev_q) < vc_x;
  assign victim_l  = LW'(victim_q);
  assign prev_l    = LW'(prev_q);
  assign head_hit  = victim_ok && (active_head == victim_l);
  assign link_hit  = victim_ok && prev_ok && (ram_rdata == victim_l);
  assign tot_inc   = XW'(active_total) < vc_x;
  assign tot_dec   = active_total != '0;
  assign clr_data  = ((XW'(clr_cnt) + XW'(1)) < vc_x) ? clr_cnt + LW'(1) : END_MARK;

  // State register
  always_ff @(posedge clk) begin
    if (rst || cfg.rebuild) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_cnt == LAST_IDX) state_next = ST_IDLE;
      ST_IDLE:  if (cmd.valid) state_next = ST_EXEC1;
      ST_EXEC1: begin
        state_next = ST_DONE;
        if (cmd_q == CMD_ALLOC_TAIL && fh_ok && active_head != END_MARK &&
            active_tail != END_MARK) begin
          state_next = ST_WR2;
        end
        if (cmd_q == CMD_FREE_AFTER && !ph_q && link_hit) begin
          state_next = ST_EXEC2;
        end
      end
      ST_EXEC2: state_next = ST_WR2;
      ST_WR2:   state_next = ST_DONE;
      ST_DONE:  if (!res.valid || res.ready) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // RAM port and handshake outputs
  always_comb begin
    // closed while a rebuild is pending
    cmd.ready = (state == ST_IDLE) && !cfg.rebuild;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt[AW-1:0];
    ram_wdata = clr_data;
    ram_raddr = AW'(victim_q);
    unique case (state)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE: begin
        unique case (cmd_t'(cmd.command))
          CMD_ALLOC_HEAD, CMD_ALLOC_TAIL: ram_raddr = free_head[AW-1:0];
          CMD_POP_HEAD:                   ram_raddr = active_head[AW-1:0];
          CMD_FREE_AFTER: ram_raddr = cmd.prev_is_head ? AW'(cmd.victim_slot)
                                                       : AW'(cmd.prev_slot);
          default: ;
        endcase
      end
      ST_EXEC1: begin
        unique case (cmd_q)
          CMD_ALLOC_HEAD: begin
            ram_we    = fh_ok;
            ram_waddr = free_head[AW-1:0];
            ram_wdata = active_head;
          end
          CMD_ALLOC_TAIL: begin
            ram_we    = fh_ok;
            ram_waddr = free_head[AW-1:0];
            ram_wdata = END_MARK;
          end
          CMD_POP_HEAD: begin
            ram_we    = ah_ok;
            ram_waddr = active_head[AW-1:0];
            ram_wdata = free_head;
          end
          CMD_FREE_AFTER: begin
            ram_we    = ph_q && head_hit;
            ram_waddr = AW'(victim_q);
            ram_wdata = free_head;
          end
          default: ;
        endcase
      end
      // predecessor skips over the victim
      ST_EXEC2: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(prev_q);
        ram_wdata = ram_rdata;
      end
      ST_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = wr2_addr;
        ram_wdata = wr2_data;
      end
      default: ;
    endcase
  end

  // List pointers and per-command datapath
  always_ff @(posedge clk) begin
    if (rst || cfg.rebuild) begin
      clr_cnt      <= '0;
      free_head    <= '0;
      active_head  <= END_MARK;
      active_tail  <= END_MARK;
      active_total <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + LW'(1);
        ST_IDLE: begin
          if (cmd.valid) begin
            cmd_q    <= cmd_t'(cmd.command);
            prev_q   <= cmd.prev_slot;
            ph_q     <= cmd.prev_is_head;
            victim_q <= cmd.victim_slot;
          end
        end
        ST_EXEC1: begin
          res_ok   <= 1'b0;
          res_slot <= '0;
          res_next <= END_MARK;
          unique case (cmd_q)
            CMD_ALLOC_HEAD, CMD_ALLOC_TAIL: begin
              if (fh_ok) begin
                free_head <= ram_rdata;
                res_ok    <= 1'b1;
                res_slot  <= free_head;
                if (tot_inc) active_total <= active_total + LW'(1);
                if (cmd_q == CMD_ALLOC_HEAD) begin
                  active_head <= free_head;
                  if (active_head == END_MARK) active_tail <= free_head;
                end else begin
                  if (active_head == END_MARK) active_head <= free_head;
                  wr2_addr    <= active_tail[AW-1:0];
                  wr2_data    <= free_head;
                  active_tail <= free_head;
                end
              end
            end
            CMD_POP_HEAD: begin
              if (ah_ok) begin
                active_head <= ram_rdata;
                if (ram_rdata == END_MARK) active_tail <= END_MARK;
                free_head <= active_head;
                if (tot_dec) active_total <= active_total - LW'(1);
                res_ok   <= 1'b1;
                res_slot <= active_head;
              end
            end
            CMD_FREE_AFTER: begin
              // victim is the head: link read above is its successor
              if (ph_q && head_hit) begin
                active_head <= ram_rdata;
                if (active_tail == victim_l) active_tail <= END_MARK;
                free_head <= victim_l;
                if (tot_dec) active_total <= active_total - LW'(1);
                res_ok   <= 1'b1;
                res_slot <= victim_l;
                res_next <= ram_rdata;
              end
            end
            default: ;
          endcase
        end
        ST_EXEC2: begin
          // ram_rdata is the victim's successor
          wr2_addr  <= AW'(victim_q);
          wr2_data  <= free_head;
          free_head <= victim_l;
          if (active_tail == victim_l) active_tail <= prev_l;
          if (tot_dec) active_total <= active_total - LW'(1);
          res_ok   <= 1'b1;
          res_slot <= victim_l;
          res_next <= ram_rdata;
        end
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (state == ST_DONE && (!res.valid || res.ready)) begin
      res.valid        <= 1'b1;
      res.ok           <= res_ok;
      res.slot         <= SLOT_W'(res_slot);
      res.next_slot    <= NEXT_W'(res_next);
      res.active_count <= CNT_W'(active_total);
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

endmodule

[hdl/voice_pool_linked_list_unit.sv]
// ----------------------------------------------------------------------------
// voice_pool_linked_list_unit
// Voice slot pool kept as a free list and an active list in one link RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | payload
//  cmd      | in  | valid/ready      | command, prev_slot, prev_is_head, victim_slot
//  res      | out | valid/ready      | ok, slot, next_slot, active_count
//  apb      | in  | psel/penable     | paddr, pwdata, prdata (voice_count at 0x0)
//
//  One command at a time through the single link RAM port pair. Allocate
//  at tail on a non-empty list adds a write-back of the old tail's link;
//  free after a given predecessor takes the most steps (read predecessor,
//  read victim, two write-backs). Reset and every voice_count write start a
//  clearing pass rechaining all POOL_SIZE entries, with cmd.ready held low.
//  A result waits in the output register; the next command is still taken.
// ----------------------------------------------------------------------------
module voice_pool_linked_list_unit #(
  parameter int POOL_SIZE = vpll_pkg::POOL_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vpll_pkg::PADDR_W-1:0] paddr,
  input  logic [vpll_pkg::PDATA_W-1:0] pwdata,
  output logic [vpll_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  vpll_cmd_if.sink                     cmd,
  vpll_res_if.source                   res
);
  import vpll_pkg::*;

  localparam int LW = $clog2(POOL_SIZE + 1);
  localparam int AW = $clog2(POOL_SIZE);

  cfg_t          cfg;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [LW-1:0] ram_rdata;

  // Register block
  vpll_cfg #(.POOL_SIZE(POOL_SIZE)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Sequencer
  vpll_ctrl #(.POOL_SIZE(POOL_SIZE), .LW(LW), .AW(AW)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Link table
  vpll_ram #(.WIDTH(LW), .DEPTH(POOL_SIZE), .ADDR_W(AW)) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // One command in flight: no second accept right after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("command accepted while another is in flight");

  // A rebuild blocks commands for the clearing pass
  a_rebuild_blocks: assert property (@(posedge clk) disable iff (rst)
    cfg.rebuild |=> !cmd.ready)
    else $error("command port open during clearing pass");

  // Link writes stay inside the pool
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (int'(ram_waddr) < POOL_SIZE))
    else $error("link write outside pool");

endmodule
